// ----- src/fqks_pkg.sv -----
// fqks_pkg: shared constants, codes, types and key normalisation for the key search queue.
// No dependencies; used by every module of the block except fqks_ram.
package fqks_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_CHARS   = 29;
    localparam int KEY_W       = KEY_CHARS * 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W       = 5;
    localparam int SERVED_W    = 16;

    typedef enum logic [1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_SEARCH  = 2'd2,
        FUNC_READ    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DISPATCH = 3'd1,
        S_FILL     = 3'd2,
        S_SCAN     = 3'd3,
        S_RESULT   = 3'd4
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    enq;
        logic    deq;
        logic    scan_start;
        logic    scan_adv;
        logic    scan_cnt_inc;
        logic    res_load;
        status_t res_status;
        logic    res_pos;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  empty;
        logic  full;
        logic  hit;
        logic  scan_last;
        logic  out_free;
    } dp_stat_t;

    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] key);
        logic [KEY_CHARS-1:0] zero;
        logic [KEY_W-1:0]     res;
        res = key;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            zero[i] = (key[8*i +: 8] == 8'd0);
        end
        for (int i = 1; i < KEY_CHARS; i++)
        begin
            if ((zero & ((KEY_CHARS'(1) << i) - KEY_CHARS'(1))) != '0)
            begin
                res[8*i +: 8] = 8'd0;
            end
        end
        return res;
    endfunction

endpackage

// ----- src/fqks_ram.sv -----
// fqks_ram: generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fqks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fqks_ctrl.sv -----
// fqks_ctrl: sequencing state machine for the key search queue.
// Depends on fqks_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module fqks_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fqks_pkg::dp_stat_t stat,
    output fqks_pkg::dp_cmd_t  cmd
);

    fqks_pkg::state_t state_reg;
    fqks_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fqks_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fqks_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fqks_pkg::S_DISPATCH;
                end
            end
            fqks_pkg::S_DISPATCH:
            begin
                if (stat.func == fqks_pkg::FUNC_SEARCH && !stat.empty)
                begin
                    state_next = fqks_pkg::S_FILL;
                end
                else
                begin
                    state_next = fqks_pkg::S_RESULT;
                end
            end
            fqks_pkg::S_FILL:
            begin
                state_next = fqks_pkg::S_SCAN;
            end
            fqks_pkg::S_SCAN:
            begin
                if (stat.hit || stat.scan_last)
                begin
                    state_next = fqks_pkg::S_RESULT;
                end
            end
            fqks_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = fqks_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fqks_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = fqks_pkg::ST_OK;
        in_stall       = 1'b1;
        case (state_reg)
            fqks_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            fqks_pkg::S_DISPATCH:
            begin
                cmd.res_load = 1'b1;
                case (stat.func)
                    fqks_pkg::FUNC_ENQUEUE:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_status = fqks_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.enq = 1'b1;
                        end
                    end
                    fqks_pkg::FUNC_DEQUEUE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_status = fqks_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.deq = 1'b1;
                        end
                    end
                    fqks_pkg::FUNC_SEARCH:
                    begin
                        cmd.res_status = fqks_pkg::ST_NOT_FOUND;
                        cmd.scan_start = !stat.empty;
                    end
                    default:
                    begin
                        cmd.res_status = fqks_pkg::ST_OK;
                    end
                endcase
            end
            fqks_pkg::S_FILL:
            begin
                cmd.scan_adv = 1'b1;
            end
            fqks_pkg::S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fqks_pkg::ST_OK;
                    cmd.res_pos    = 1'b1;
                end
                else if (stat.scan_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = fqks_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    cmd.scan_adv     = 1'b1;
                    cmd.scan_cnt_inc = 1'b1;
                end
            end
            fqks_pkg::S_RESULT:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- src/fqks_dp.sv -----
// fqks_dp: key store, queue pointers, served counter, scan logic and output register.
// Depends on fqks_pkg and fqks_ram; obeys dp_cmd_t from fqks_ctrl.
module fqks_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fqks_pkg::dp_cmd_t                 cmd,
    output fqks_pkg::dp_stat_t                stat,
    input  logic [1:0]                        func,
    input  logic [63:0]                       key_bytes_a,
    input  logic [63:0]                       key_bytes_b,
    input  logic [63:0]                       key_bytes_c,
    input  logic [39:0]                       key_bytes_d,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [fqks_pkg::POS_W-1:0]        position,
    output logic [fqks_pkg::SERVED_W-1:0]     served_total
);

    localparam logic [fqks_pkg::IDX_W-1:0] LAST_IDX = fqks_pkg::IDX_W'(fqks_pkg::QUEUE_DEPTH - 1);
    localparam logic [fqks_pkg::CNT_W-1:0] FULL_CNT = fqks_pkg::CNT_W'(fqks_pkg::QUEUE_DEPTH);

    fqks_pkg::func_t                  func_reg;
    logic [fqks_pkg::KEY_W-1:0]       key_reg;
    logic [fqks_pkg::KEY_W-1:0]       rd_data;

    logic [fqks_pkg::IDX_W-1:0]       head_reg, head_next;
    logic [fqks_pkg::IDX_W-1:0]       tail_reg, tail_next;
    logic [fqks_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [fqks_pkg::SERVED_W-1:0]    served_reg, served_next;
    logic [fqks_pkg::IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [fqks_pkg::IDX_W-1:0]       scan_cnt_reg, scan_cnt_next;
    fqks_pkg::status_t                res_status_reg, res_status_next;
    logic [fqks_pkg::POS_W-1:0]       res_pos_reg, res_pos_next;
    logic                             out_valid_reg, out_valid_next;
    fqks_pkg::status_t                out_status_reg, out_status_next;
    logic [fqks_pkg::POS_W-1:0]       out_pos_reg, out_pos_next;
    logic [fqks_pkg::SERVED_W-1:0]    out_served_reg, out_served_next;
    logic [fqks_pkg::CNT_W-1:0]       scan_pos;

    function automatic logic [fqks_pkg::IDX_W-1:0] next_idx(input logic [fqks_pkg::IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + fqks_pkg::IDX_W'(1);
    endfunction

    fqks_ram #(
        .WIDTH (fqks_pkg::KEY_W),
        .DEPTH (fqks_pkg::QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.enq),
        .waddr (tail_reg),
        .wdata (key_reg),
        .raddr (scan_idx_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= fqks_pkg::func_t'(func);
            key_reg  <= fqks_pkg::normalize_key({key_bytes_d, key_bytes_c,
                                                 key_bytes_b, key_bytes_a});
        end
    end

    assign scan_pos = fqks_pkg::CNT_W'(scan_cnt_reg) + fqks_pkg::CNT_W'(1);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        served_next     = served_reg;
        scan_idx_next   = scan_idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_served_next = out_served_reg;
        if (cmd.enq)
        begin
            tail_next  = next_idx(tail_reg);
            count_next = count_reg + fqks_pkg::CNT_W'(1);
        end
        if (cmd.deq)
        begin
            head_next  = next_idx(head_reg);
            count_next = count_reg - fqks_pkg::CNT_W'(1);
            if (served_reg != '1)
            begin
                served_next = served_reg + fqks_pkg::SERVED_W'(1);
            end
        end
        if (cmd.scan_start)
        begin
            scan_idx_next = head_reg;
            scan_cnt_next = '0;
        end
        if (cmd.scan_adv)
        begin
            scan_idx_next = next_idx(scan_idx_reg);
        end
        if (cmd.scan_cnt_inc)
        begin
            scan_cnt_next = scan_cnt_reg + fqks_pkg::IDX_W'(1);
        end
        if (cmd.res_load)
        begin
            res_status_next = cmd.res_status;
            res_pos_next    = cmd.res_pos ? fqks_pkg::POS_W'(scan_pos) : '0;
        end
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_pos_next    = res_pos_reg;
            out_served_next = served_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            served_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            served_reg    <= served_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        scan_cnt_reg   <= scan_cnt_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_served_reg <= out_served_next;
    end

    assign stat.func      = func_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == FULL_CNT);
    assign stat.hit       = (rd_data == key_reg);
    assign stat.scan_last = (scan_pos == count_reg);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign position     = out_pos_reg;
    assign served_total = out_served_reg;

endmodule

// ----- src/fifo_queue_with_key_search.sv -----
// fifo_queue_with_key_search: top level of the key search queue; joins fqks_ctrl and fqks_dp.
// Depends on fqks_pkg, fqks_ctrl, fqks_dp and fqks_ram.
// Each transfer in passes through S_DISPATCH and S_RESULT; a search of a non-empty queue also
// passes through S_FILL and S_SCAN, comparing N entries one per cycle (at most QUEUE_DEPTH).
// No new transfer is taken (in_stall high) until the result is loaded into the output register.
// Reset (rst_n, asynchronous) empties the queue and clears the served count; no clearing pass.
module fifo_queue_with_key_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [63:0]                   key_bytes_a,
    input  logic [63:0]                   key_bytes_b,
    input  logic [63:0]                   key_bytes_c,
    input  logic [39:0]                   key_bytes_d,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [fqks_pkg::POS_W-1:0]    position,
    output logic [fqks_pkg::SERVED_W-1:0] served_total
);

    fqks_pkg::dp_cmd_t  cmd;
    fqks_pkg::dp_stat_t stat;

    fqks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fqks_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (func),
        .key_bytes_a  (key_bytes_a),
        .key_bytes_b  (key_bytes_b),
        .key_bytes_c  (key_bytes_c),
        .key_bytes_d  (key_bytes_d),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .position     (position),
        .served_total (served_total)
    );

endmodule

// ----- src/fqks_checker.sv -----
// fqks_checker: port-level assertions for the key search queue, bound to the top level.
// Depends on fqks_pkg and fifo_queue_with_key_search.
module fqks_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [1:0]                    func,
    input logic [63:0]                   key_bytes_a,
    input logic [63:0]                   key_bytes_b,
    input logic [63:0]                   key_bytes_c,
    input logic [39:0]                   key_bytes_d,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    status,
    input logic [fqks_pkg::POS_W-1:0]    position,
    input logic [fqks_pkg::SERVED_W-1:0] served_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(position)
                                   && $stable(served_total))
        else $error("stalled result changed");

    a_pos_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != fqks_pkg::ST_OK |-> position == '0)
        else $error("position given without a match");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while an item is in progress");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in progress");

endmodule

bind fifo_queue_with_key_search fqks_checker u_fqks_checker (.*);

// ----- bench/queue_search_checker.sv -----
// Checker for the key search queue: watches both channels, predicts each result and compares it.
// Depends on fqks_pkg for widths, operation codes and status codes.
`timescale 1ns / 1ps

module queue_search_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [63:0]                   key_bytes_a,
    input  logic [63:0]                   key_bytes_b,
    input  logic [63:0]                   key_bytes_c,
    input  logic [39:0]                   key_bytes_d,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    status,
    input  logic [fqks_pkg::POS_W-1:0]    position,
    input  logic [fqks_pkg::SERVED_W-1:0] served_total,
    output int                            mismatches,
    output int                            replies_owed
);

    localparam int SERVED_MAX = (1 << fqks_pkg::SERVED_W) - 1;

    typedef struct packed {
        fqks_pkg::status_t             st;
        logic [fqks_pkg::POS_W-1:0]    pos;
        logic [fqks_pkg::SERVED_W-1:0] served;
    } reply_t;

    logic [fqks_pkg::KEY_W-1:0] stored_keys [fqks_pkg::QUEUE_DEPTH];
    int                         head_ptr;
    int                         tail_ptr;
    int                         fill_level;
    int                         served_cnt;
    reply_t                     expected_replies [$];

    function automatic logic [fqks_pkg::KEY_W-1:0] clean_key(
        input logic [fqks_pkg::KEY_W-1:0] raw);
        logic [fqks_pkg::KEY_W-1:0] k;
        logic                       ended;
        k = raw;
        ended = 1'b0;
        for (int i = 0; i < fqks_pkg::KEY_CHARS; i++)
        begin
            if (ended)
                k[8*i +: 8] = 8'd0;
            else if (k[8*i +: 8] == 8'd0)
                ended = 1'b1;
        end
        return k;
    endfunction

    task automatic predict_queue_op(input fqks_pkg::func_t op,
                                    input logic [fqks_pkg::KEY_W-1:0] raw,
                                    output reply_t r);
        logic [fqks_pkg::KEY_W-1:0] k;
        int                         idx;
        k = clean_key(raw);
        r.st = fqks_pkg::ST_OK;
        r.pos = '0;
        case (op)
            fqks_pkg::FUNC_ENQUEUE:
            begin
                if (fill_level >= fqks_pkg::QUEUE_DEPTH)
                    r.st = fqks_pkg::ST_FULL;
                else
                begin
                    stored_keys[tail_ptr] = k;
                    tail_ptr = (tail_ptr + 1) % fqks_pkg::QUEUE_DEPTH;
                    fill_level++;
                end
            end
            fqks_pkg::FUNC_DEQUEUE:
            begin
                if (fill_level == 0)
                    r.st = fqks_pkg::ST_EMPTY;
                else
                begin
                    head_ptr = (head_ptr + 1) % fqks_pkg::QUEUE_DEPTH;
                    fill_level--;
                    if (served_cnt < SERVED_MAX)
                        served_cnt++;
                end
            end
            fqks_pkg::FUNC_SEARCH:
            begin
                r.st = fqks_pkg::ST_NOT_FOUND;
                idx = head_ptr;
                for (int i = 0; i < fill_level; i++)
                begin
                    if (stored_keys[idx] == k)
                    begin
                        r.st = fqks_pkg::ST_OK;
                        r.pos = fqks_pkg::POS_W'(i + 1);
                        break;
                    end
                    idx = (idx + 1) % fqks_pkg::QUEUE_DEPTH;
                end
            end
            fqks_pkg::FUNC_READ:
            begin
            end
        endcase
        r.served = fqks_pkg::SERVED_W'(served_cnt);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            head_ptr = 0;
            tail_ptr = 0;
            fill_level = 0;
            served_cnt = 0;
            mismatches = 0;
            expected_replies.delete();
            replies_owed = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected transfer out: status %0d position %0d served_total %0d",
                           status, position, served_total);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        mismatches++;
                    end
                    if (position !== want.pos)
                    begin
                        $error("position: expected %0d, got %0d", want.pos, position);
                        mismatches++;
                    end
                    if (served_total !== want.served)
                    begin
                        $error("served_total: expected %0d, got %0d", want.served, served_total);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_queue_op(fqks_pkg::func_t'(func),
                                 {key_bytes_d, key_bytes_c, key_bytes_b, key_bytes_a}, want);
                expected_replies.push_back(want);
            end
            replies_owed = expected_replies.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Testbench top for the key search queue: clock, reset, stimulus, receiver stalls and verdict.
// Depends on fqks_pkg, fifo_queue_with_key_search and queue_search_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS   = 750;
    localparam int TAIL_ITEMS     = 20;
    localparam int POOL_SIZE      = 10;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 500000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    func;
    logic [63:0]                   key_bytes_a;
    logic [63:0]                   key_bytes_b;
    logic [63:0]                   key_bytes_c;
    logic [39:0]                   key_bytes_d;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    status;
    logic [fqks_pkg::POS_W-1:0]    position;
    logic [fqks_pkg::SERVED_W-1:0] served_total;
    int                            mismatches;
    int                            replies_owed;

    logic                       press_req;
    logic                       press_done;
    int                         burst_left;
    int                         cycle_count = 0;
    logic [fqks_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    fifo_queue_with_key_search u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .key_bytes_a  (key_bytes_a),
        .key_bytes_b  (key_bytes_b),
        .key_bytes_c  (key_bytes_c),
        .key_bytes_d  (key_bytes_d),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .position     (position),
        .served_total (served_total)
    );

    queue_search_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .key_bytes_a  (key_bytes_a),
        .key_bytes_b  (key_bytes_b),
        .key_bytes_c  (key_bytes_c),
        .key_bytes_d  (key_bytes_d),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .position     (position),
        .served_total (served_total),
        .mismatches   (mismatches),
        .replies_owed (replies_owed)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [fqks_pkg::KEY_W-1:0] random_key();
        logic [fqks_pkg::KEY_W-1:0] k;
        int                         len;
        int                         shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < fqks_pkg::KEY_CHARS; i++)
            k[8*i +: 8] = 8'($urandom_range(0, 255));
        if (shape == 0)
            len = fqks_pkg::KEY_CHARS;
        else if (shape < 3)
            len = $urandom_range(0, fqks_pkg::KEY_CHARS);
        else
            len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            if (k[8*i +: 8] == 8'd0)
                k[8*i +: 8] = 8'($urandom_range(1, 255));
        if (len < fqks_pkg::KEY_CHARS)
            k[8*len +: 8] = 8'd0;
        if (shape > 6)
            for (int i = len + 1; i < fqks_pkg::KEY_CHARS; i++)
                k[8*i +: 8] = 8'd0;
        return k;
    endfunction

    // Refill everything after the terminator with noise.
    function automatic logic [fqks_pkg::KEY_W-1:0] scramble_tail(
        input logic [fqks_pkg::KEY_W-1:0] key);
        logic [fqks_pkg::KEY_W-1:0] k;
        logic                       ended;
        k = key;
        ended = 1'b0;
        for (int i = 0; i < fqks_pkg::KEY_CHARS; i++)
        begin
            if (ended)
                k[8*i +: 8] = 8'($urandom_range(0, 255));
            else if (k[8*i +: 8] == 8'd0)
                ended = 1'b1;
        end
        return k;
    endfunction

    function automatic logic [fqks_pkg::KEY_W-1:0] pick_key();
        int r;
        int slot;
        r = $urandom_range(0, 9);
        slot = $urandom_range(0, POOL_SIZE - 1);
        if (r < 6)
            return scramble_tail(key_pool[slot]);
        if (r < 7)
        begin
            key_pool[slot] = random_key();
            return key_pool[slot];
        end
        return random_key();
    endfunction

    task automatic sender_gap();
        int r;
        int n;
        n = 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            n = 0;
        else if (r < 88)
            n = $urandom_range(1, 3);
        else if (r < 95)
            n = $urandom_range(8, 40);
        else
            burst_left = $urandom_range(10, 30);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic offer_item(input fqks_pkg::func_t op, input logic [fqks_pkg::KEY_W-1:0] k);
        @(negedge clk);
        in_valid    <= 1'b1;
        func        <= op;
        key_bytes_a <= k[63:0];
        key_bytes_b <= k[127:64];
        key_bytes_c <= k[191:128];
        key_bytes_d <= k[231:192];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sender_gap();
    endtask

    task automatic random_op(input int mode);
        int              r;
        int              enq_w;
        int              deq_w;
        fqks_pkg::func_t op;
        case (mode)
            0:
            begin
                enq_w = 55;
                deq_w = 10;
            end
            1:
            begin
                enq_w = 10;
                deq_w = 55;
            end
            default:
            begin
                enq_w = 30;
                deq_w = 30;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < enq_w)
            op = fqks_pkg::FUNC_ENQUEUE;
        else if (r < enq_w + deq_w)
            op = fqks_pkg::FUNC_DEQUEUE;
        else if (r < 90)
            op = fqks_pkg::FUNC_SEARCH;
        else
            op = fqks_pkg::FUNC_READ;
        offer_item(op, pick_key());
    endtask

    initial
    begin
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left = 0;
        press_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && rst_n)
            begin
                if (press_req && !press_done)
                begin
                    stall_left = LONG_HOLD;
                    press_done = 1'b1;
                end
                else
                begin
                    if (calm_left > 0)
                        calm_left--;
                    else
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 4)
                            calm_left = $urandom_range(20, 80);
                        else if (r < 7)
                            stall_left = $urandom_range(15, 50);
                        else if (r < 30)
                            stall_left = $urandom_range(1, 3);
                    end
                end
            end
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    initial
    begin
        logic [fqks_pkg::KEY_W-1:0] k;
        logic [fqks_pkg::KEY_W-1:0] abc_key;
        int                         mode;
        int                         mode_left;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        key_bytes_a = '0;
        key_bytes_b = '0;
        key_bytes_c = '0;
        key_bytes_d = '0;
        press_req = 1'b0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        offer_item(fqks_pkg::FUNC_DEQUEUE, '0);
        offer_item(fqks_pkg::FUNC_SEARCH, '1);
        offer_item(fqks_pkg::FUNC_ENQUEUE, '0);
        offer_item(fqks_pkg::FUNC_ENQUEUE, '1);
        abc_key = random_key();
        abc_key[31:0] = 32'h00636261;
        offer_item(fqks_pkg::FUNC_ENQUEUE, abc_key);
        k = random_key();
        k[7:0] = 8'd0;
        offer_item(fqks_pkg::FUNC_SEARCH, k);
        offer_item(fqks_pkg::FUNC_SEARCH, '1);
        offer_item(fqks_pkg::FUNC_SEARCH, scramble_tail(abc_key));
        k = '0;
        k[23:0] = 24'h7a7a7a;
        offer_item(fqks_pkg::FUNC_SEARCH, k);
        offer_item(fqks_pkg::FUNC_DEQUEUE, '1);
        for (int i = 0; i < fqks_pkg::QUEUE_DEPTH - 2; i++)
        begin
            k = random_key();
            key_pool[i % POOL_SIZE] = k;
            offer_item(fqks_pkg::FUNC_ENQUEUE, k);
        end
        offer_item(fqks_pkg::FUNC_ENQUEUE, random_key());
        offer_item(fqks_pkg::FUNC_SEARCH, scramble_tail(k));
        offer_item(fqks_pkg::FUNC_READ, '1);

        press_req = 1'b1;
        mode = 2;
        mode_left = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(30, 60);
            end
            mode_left--;
            random_op(mode);
        end

        for (int i = 0; i < TAIL_ITEMS; i++)
            random_op(2);

        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
